// ----- rtl/ctc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the command token classifier.
// No dependencies; imported by every module of the block.
package ctc_pkg;

   // Message framing
   localparam int MAX_TOKENS     = 3;
   localparam int MAX_HEX_DIGITS = 4;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_X     = 8'h78;

   // Characters seen in the open token, saturating
   localparam int POS_W = 4;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Token counter wide enough for MAX_TOKENS, never narrower than the 2-bit ports
   localparam int TOK_CLOG = $clog2(MAX_TOKENS + 1);
   localparam int TOK_W    = (TOK_CLOG > 2) ? TOK_CLOG : 2;

   localparam int NUM_KW  = 3;
   localparam int VALUE_W = 16;

   // Result queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 3;

   typedef enum logic [1:0] {
      KIND_KEYWORD = 2'd0,
      KIND_NUMBER  = 2'd1,
      KIND_STRING  = 2'd2
   } token_kind_type;

   typedef enum logic [1:0] {
      KW_LOAD  = 2'd0,
      KW_STORE = 2'd1,
      KW_RESET = 2'd2
   } kw_code_type;

   typedef struct packed {
      logic                 token_valid;
      logic [1:0]           token_index;
      token_kind_type       token_kind;
      kw_code_type          keyword_code;
      logic [VALUE_W-1:0]   number_value;
      logic                 message_end;
      logic [1:0]           token_count;
   } result_type;

   function automatic logic [POS_W-1:0] kw_len(input kw_code_type k);
      case (k)
         KW_LOAD:  kw_len = POS_W'(4);
         KW_STORE: kw_len = POS_W'(5);
         KW_RESET: kw_len = POS_W'(5);
         default:  kw_len = '0;
      endcase
   endfunction

   // Character of keyword k at position p, 0 past its end
   function automatic logic [7:0] kw_char(input kw_code_type k, input logic [POS_W-1:0] p);
      logic [7:0] ch;
      ch = 8'h00;
      case (k)
         KW_LOAD: begin
            case (p)
               POS_W'(0): ch = "l";
               POS_W'(1): ch = "o";
               POS_W'(2): ch = "a";
               POS_W'(3): ch = "d";
               default:   ch = 8'h00;
            endcase
         end
         KW_STORE: begin
            case (p)
               POS_W'(0): ch = "s";
               POS_W'(1): ch = "t";
               POS_W'(2): ch = "o";
               POS_W'(3): ch = "r";
               POS_W'(4): ch = "e";
               default:   ch = 8'h00;
            endcase
         end
         KW_RESET: begin
            case (p)
               POS_W'(0): ch = "r";
               POS_W'(1): ch = "e";
               POS_W'(2): ch = "s";
               POS_W'(3): ch = "e";
               POS_W'(4): ch = "t";
               default:   ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      kw_char = ch;
   endfunction

   // {is_hex_digit, nibble} for uppercase hex
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
         hex_nibble = {1'b1, d[3:0]};
      end else if (c >= CHAR_A && c <= CHAR_F) begin
         d = c - CHAR_A + 8'd10;
         hex_nibble = {1'b1, d[3:0]};
      end else begin
         hex_nibble = {1'b0, d[3:0]};
      end
   endfunction

endpackage

// ----- rtl/ctc_front.sv -----
`timescale 1ns / 1ps
// Front end: takes one character per transaction, tracks token state and
// classifies tokens as they close. Depends on ctc_pkg.
module ctc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ctc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            q_ready,
   output logic                            q_push,
   output ctc_pkg::result_type             q_data
);
   import ctc_pkg::*;

   logic                 inside_ff, inside_in;
   logic [TOK_W-1:0]     tokens_ff, tokens_in;
   logic                 ignore_ff, ignore_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [NUM_KW-1:0]    cand_ff, cand_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic                 hexok_ff, hexok_in;

   logic                 accept;
   logic [7:0]           c;
   logic                 is_end, is_space;

   // take-character datapath, from either the open token or a fresh one
   logic [POS_W-1:0]     base_pos;
   logic [NUM_KW-1:0]    base_cand;
   logic [VALUE_W-1:0]   base_acc;
   logic                 base_hexok;
   logic [NUM_KW-1:0]    take_cand;
   logic [VALUE_W-1:0]   take_acc;
   logic                 take_hexok;
   logic [POS_W-1:0]     take_pos;
   logic [POS_W:0]       digit_idx;
   logic [4:0]           nib;

   result_type           close_rec;
   logic                 at_limit;

   assign req_tready = q_ready;
   assign accept     = req_tvalid & req_tready;
   assign c          = req_tdata;
   assign is_end     = (c == CHAR_END);
   assign is_space   = (c == CHAR_SPACE);
   assign at_limit   = (tokens_ff >= TOK_W'(MAX_TOKENS));

   always_comb begin
      base_pos   = inside_ff ? pos_ff   : '0;
      base_cand  = inside_ff ? cand_ff  : '1;
      base_acc   = inside_ff ? acc_ff   : '0;
      base_hexok = inside_ff ? hexok_ff : 1'b1;

      take_cand = base_cand;
      for (int k = 0; k < NUM_KW; k++) begin
         if (base_pos >= kw_len(kw_code_type'(k)) || kw_char(kw_code_type'(k), base_pos) != c)
            take_cand[k] = 1'b0;
      end

      take_hexok = base_hexok;
      take_acc   = base_acc;
      digit_idx  = {1'b0, base_pos} - (POS_W+1)'(2);
      nib        = hex_nibble(c);
      if (base_pos == POS_W'(0)) begin
         if (c != CHAR_ZERO) take_hexok = 1'b0;
      end else if (base_pos == POS_W'(1)) begin
         if (c != CHAR_X) take_hexok = 1'b0;
      end else if (base_pos == POS_MAX || digit_idx >= (POS_W+1)'(MAX_HEX_DIGITS)) begin
         take_hexok = 1'b0;
      end else begin
         if (!nib[4]) take_hexok = 1'b0;
         if (take_hexok) take_acc = {base_acc[VALUE_W-5:0], nib[3:0]};
      end

      take_pos = (base_pos == POS_MAX) ? base_pos : base_pos + 1'b1;
   end

   // classification of the open token
   always_comb begin
      close_rec              = '0;
      close_rec.token_valid  = 1'b1;
      close_rec.token_index  = 2'(tokens_ff - 1'b1);
      close_rec.token_kind   = KIND_STRING;
      close_rec.keyword_code = KW_LOAD;
      close_rec.token_count  = tokens_ff[1:0];
      for (int k = 0; k < NUM_KW; k++) begin
         if (cand_ff[k] && pos_ff == kw_len(kw_code_type'(k))) begin
            close_rec.token_kind   = KIND_KEYWORD;
            close_rec.keyword_code = kw_code_type'(k);
         end
      end
      if (close_rec.token_kind != KIND_KEYWORD && hexok_ff && pos_ff >= POS_W'(3)) begin
         close_rec.token_kind   = KIND_NUMBER;
         close_rec.number_value = acc_ff;
      end
   end

   always_comb begin
      inside_in = inside_ff;
      tokens_in = tokens_ff;
      ignore_in = ignore_ff;
      pos_in    = pos_ff;
      cand_in   = cand_ff;
      acc_in    = acc_ff;
      hexok_in  = hexok_ff;
      q_push    = 1'b0;
      q_data    = '0;

      if (accept) begin
         if (is_end) begin
            q_push = 1'b1;
            if (inside_ff) q_data = close_rec;
            q_data.message_end = 1'b1;
            q_data.token_count = tokens_ff[1:0];
            inside_in = 1'b0;
            tokens_in = '0;
            ignore_in = 1'b0;
            pos_in    = '0;
            cand_in   = '1;
            acc_in    = '0;
            hexok_in  = 1'b1;
         end else if (inside_ff) begin
            if (is_space) begin
               q_push    = 1'b1;
               q_data    = close_rec;
               inside_in = 1'b0;
               if (at_limit) ignore_in = 1'b1;
            end else begin
               pos_in   = take_pos;
               cand_in  = take_cand;
               acc_in   = take_acc;
               hexok_in = take_hexok;
            end
         end else if (!(ignore_ff || at_limit || is_space)) begin
            tokens_in = tokens_ff + 1'b1;
            inside_in = 1'b1;
            pos_in    = take_pos;
            cand_in   = take_cand;
            acc_in    = take_acc;
            hexok_in  = take_hexok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         tokens_ff <= '0;
         ignore_ff <= 1'b0;
         pos_ff    <= '0;
         cand_ff   <= '1;
         acc_ff    <= '0;
         hexok_ff  <= 1'b1;
      end else begin
         inside_ff <= inside_in;
         tokens_ff <= tokens_in;
         ignore_ff <= ignore_in;
         pos_ff    <= pos_in;
         cand_ff   <= cand_in;
         acc_ff    <= acc_in;
         hexok_ff  <= hexok_in;
      end
   end

endmodule

// ----- rtl/ctc_queue.sv -----
`timescale 1ns / 1ps
// Short result queue between front and back end.
// Depends on ctc_pkg.
module ctc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ctc_pkg::result_type push_data,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output ctc_pkg::result_type pop_data
);
   import ctc_pkg::*;

   result_type           slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- rtl/ctc_back.sv -----
`timescale 1ns / 1ps
// Back end: pulls classified results from the queue into the output register
// and drives the result stream. Depends on ctc_pkg.
module ctc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  ctc_pkg::result_type             q_data,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ctc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [ctc_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import ctc_pkg::*;

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;

   // refill whenever the queue holds a result and the register is empty or being drained this cycle
   assign q_pop        = q_valid & (~out_valid_ff | rsp_tready);
   assign out_valid_in = q_pop | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) out_ff <= q_data;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.message_end;
   assign rsp_tuser  = {out_ff.token_kind, out_ff.token_valid};
   assign rsp_tdata  = {2'b00, out_ff.token_count, out_ff.number_value,
                        out_ff.keyword_code, out_ff.token_index};

endmodule

// ----- rtl/command_token_classifier.sv -----
`timescale 1ns / 1ps
// Top level of the command token classifier: front end, result queue, back end.
// Depends on ctc_pkg, ctc_front, ctc_queue and ctc_back.

// Splits a command message, one character per request transaction, into
// space-separated tokens (byte 0 ends the message; only the first three tokens
// count, later characters up to the end byte are dropped). Each closing token
// yields one response transaction with its index and kind: keyword (load,
// store, reset), number ("0x" plus one to four uppercase hex digits) or string.
// The end byte always yields a response with tlast set and the token count, and
// then clears all message state. Characters are taken one per cycle with no
// bubbles while the queue has room. The front end and back end are decoupled
// by a two-entry result queue plus the output register, which each response
// passes through in that order, so a stalled response port only stops character
// intake once both are full. No configuration and no clearing pass after reset.
module command_token_classifier (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ctc_pkg::REQ_TDATA_W-1:0] req_tdata,  // [7:0] char_in
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ctc_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [1:0] token_index,
                                                       // [3:2] keyword_code,
                                                       // [19:4] number_value,
                                                       // [21:20] token_count
   output logic [ctc_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // [0] token_valid,
                                                       // [2:1] token_kind
   output logic                            rsp_tlast   // message_end
);
   import ctc_pkg::*;

   logic        q_ready;   // queue has room
   logic        q_push;    // front end closes a token or sees the end byte
   result_type  q_wdata;
   logic        q_valid;
   logic        q_pop;
   result_type  q_rdata;

   // tokenizer and classifier, one character per transaction
   ctc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   // decoupling queue
   ctc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_rdata)
   );

   // output register and stream packing
   ctc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
